FILE: rtl/utf8n_pkg.sv
// Shared types and constants for the UTF-8 source normalizer.
package utf8n_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNC     = 3'd1,
    ST_INVALID   = 3'd2,
    ST_OVERLONG  = 3'd3,
    ST_SURROGATE = 3'd4,
    ST_RANGE     = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    logic        done;
    status_t     status;
    logic [31:0] offset;
    logic        multibyte;
  } result_t;

  localparam logic [20:0] SurrogateLo = 21'h00D800;
  localparam logic [20:0] SurrogateHi = 21'h00DFFF;
  localparam logic [20:0] MaxCodepoint = 21'h10FFFF;
  localparam logic [20:0] MinTwoByte = 21'h000080;
  localparam logic [20:0] MinThreeByte = 21'h000800;
  localparam logic [20:0] MinFourByte = 21'h010000;
  localparam logic [20:0] ByteOrderMark = 21'h00FEFF;
  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;

endpackage

FILE: rtl/utf8_source_normalizer.sv
// UTF-8 source normalizer: byte decoder, line-ending fixup and result queue.
//
// Input channel: one raw document byte per beat (in_data_byte), with
// in_end_of_doc high on the final byte of a document. Result channel: one
// normalized byte or one status-only beat per ready cycle. A leading byte-order
// mark is dropped, CR becomes LF and an LF directly after CR is swallowed.
// Multibyte characters are held until complete and valid, then released
// as up to four beats. The first failure latches a status code and the
// lead-byte offset; the receiver discards bytes already delivered. The last
// beat of a document carries out_doc_done and the final status.
// Each accepted byte is decoded in the cycle it is accepted and its results
// are registered into an eight-entry queue. The block takes one byte per cycle
// while at most four queue entries are occupied, which sustains one byte per
// cycle because a document never yields more results than bytes. When the
// receiver stalls the queue fills and in_ready drops. Reset empties the
// queue and clears all decoder state; the decoder also returns to its reset
// state after each end of document.
module utf8_source_normalizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_doc,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_byte,
  output logic        out_byte_valid,
  output logic        out_doc_done,
  output logic [2:0]  out_status,
  output logic [31:0] out_error_offset,
  output logic        out_had_multibyte
);
  import utf8n_pkg::*;

  localparam int Depth = 8;

  logic [31:0] byte_offset_r, byte_offset_nxt;
  logic [31:0] lead_offset_r, lead_offset_nxt;
  logic [7:0]  pend_r [3];
  logic [7:0]  pend_nxt [3];
  logic [1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [1:0]  need_cnt_r, need_cnt_nxt;
  logic [20:0] cp_r, cp_nxt;
  logic        after_cr_r, after_cr_nxt;
  status_t     err_r, err_nxt;
  logic [31:0] err_pos_r, err_pos_nxt;
  logic        mb_r, mb_nxt;

  result_t     fifo_r [Depth];
  logic [2:0]  head_r, tail_r;
  logic [3:0]  count_r, count_nxt;

  result_t     ent [4];
  logic [7:0]  emit [4];
  logic [2:0]  n_emit;
  logic [2:0]  n_wr;
  logic [20:0] cp_acc;
  logic [20:0] lowest;
  logic        in_acc, out_acc;

  assign in_ready = (count_r <= 4'd4);
  assign in_acc = in_valid && in_ready;
  assign out_valid = (count_r != 4'd0);
  assign out_acc = out_valid && out_ready;

  always_comb begin
    byte_offset_nxt = byte_offset_r + 32'd1;
    lead_offset_nxt = lead_offset_r;
    pend_nxt = pend_r;
    pend_cnt_nxt = pend_cnt_r;
    need_cnt_nxt = need_cnt_r;
    cp_nxt = cp_r;
    after_cr_nxt = after_cr_r;
    err_nxt = err_r;
    err_pos_nxt = err_pos_r;
    mb_nxt = mb_r;
    emit[0] = pend_r[0];
    emit[1] = pend_r[1];
    emit[2] = pend_r[2];
    emit[3] = 8'h00;
    n_emit = 3'd0;
    cp_acc = {cp_r[14:0], in_data_byte[5:0]};
    unique case (pend_cnt_r)
      2'd1:    lowest = MinTwoByte;
      2'd2:    lowest = MinThreeByte;
      default: lowest = MinFourByte;
    endcase

    if (err_r == ST_OK) begin
      if (need_cnt_r != 2'd0) begin
        if (in_data_byte[7:6] != 2'b10) begin
          err_nxt = ST_INVALID;
          err_pos_nxt = lead_offset_r;
          need_cnt_nxt = 2'd0;
          pend_cnt_nxt = 2'd0;
        end else begin
          cp_nxt = cp_acc;
          need_cnt_nxt = need_cnt_r - 2'd1;
          if (need_cnt_r != 2'd1) begin
            if (pend_cnt_r != 2'd3) begin
              pend_nxt[pend_cnt_r] = in_data_byte;
              pend_cnt_nxt = pend_cnt_r + 2'd1;
            end
          end else begin
            priority if (cp_acc < lowest) begin
              err_nxt = ST_OVERLONG;
              err_pos_nxt = lead_offset_r;
              pend_cnt_nxt = 2'd0;
            end else if (cp_acc >= SurrogateLo && cp_acc <= SurrogateHi) begin
              err_nxt = ST_SURROGATE;
              err_pos_nxt = lead_offset_r;
              pend_cnt_nxt = 2'd0;
            end else if (cp_acc > MaxCodepoint) begin
              err_nxt = ST_RANGE;
              err_pos_nxt = lead_offset_r;
              pend_cnt_nxt = 2'd0;
            end else begin
              if (!(pend_cnt_r == 2'd2 && lead_offset_r == 32'd0 &&
                    cp_acc == ByteOrderMark)) begin
                emit[pend_cnt_r] = in_data_byte;
                n_emit = {1'b0, pend_cnt_r} + 3'd1;
                mb_nxt = 1'b1;
              end
              pend_cnt_nxt = 2'd0;
            end
          end
        end
      end else if (!in_data_byte[7]) begin
        priority if (in_data_byte == CharCr) begin
          emit[0] = CharLf;
          n_emit = 3'd1;
          after_cr_nxt = 1'b1;
        end else if (in_data_byte == CharLf && after_cr_r) begin
          after_cr_nxt = 1'b0;
        end else begin
          emit[0] = in_data_byte;
          n_emit = 3'd1;
          after_cr_nxt = 1'b0;
        end
      end else begin
        after_cr_nxt = 1'b0;
        if (in_data_byte[7:6] == 2'b10 || in_data_byte[7:3] == 5'b11111) begin
          err_nxt = ST_INVALID;
          err_pos_nxt = byte_offset_r;
          need_cnt_nxt = 2'd0;
          pend_cnt_nxt = 2'd0;
        end else begin
          lead_offset_nxt = byte_offset_r;
          pend_nxt[0] = in_data_byte;
          pend_cnt_nxt = 2'd1;
          priority if (!in_data_byte[5]) begin
            cp_nxt = {16'd0, in_data_byte[4:0]};
            need_cnt_nxt = 2'd1;
          end else if (!in_data_byte[4]) begin
            cp_nxt = {17'd0, in_data_byte[3:0]};
            need_cnt_nxt = 2'd2;
          end else begin
            cp_nxt = {18'd0, in_data_byte[2:0]};
            need_cnt_nxt = 2'd3;
          end
        end
      end
      if (in_end_of_doc && err_nxt == ST_OK && need_cnt_nxt != 2'd0) begin
        err_nxt = ST_TRUNC;
        err_pos_nxt = lead_offset_nxt;
        need_cnt_nxt = 2'd0;
        pend_cnt_nxt = 2'd0;
      end
    end

    for (int k = 0; k < 4; k++) begin
      ent[k].data = emit[k];
      ent[k].valid = 1'b1;
      ent[k].done = in_end_of_doc && (3'(k) == n_emit - 3'd1);
      ent[k].status = err_nxt;
      ent[k].offset = (err_nxt != ST_OK) ? err_pos_nxt : 32'd0;
      ent[k].multibyte = mb_nxt;
    end
    n_wr = n_emit;
    if (n_emit == 3'd0 && in_end_of_doc) begin
      ent[0].data = 8'h00;
      ent[0].valid = 1'b0;
      ent[0].done = 1'b1;
      n_wr = 3'd1;
    end

    if (in_end_of_doc) begin
      byte_offset_nxt = 32'd0;
      lead_offset_nxt = 32'd0;
      pend_nxt[0] = 8'h00;
      pend_nxt[1] = 8'h00;
      pend_nxt[2] = 8'h00;
      pend_cnt_nxt = 2'd0;
      need_cnt_nxt = 2'd0;
      cp_nxt = 21'd0;
      after_cr_nxt = 1'b0;
      err_nxt = ST_OK;
      err_pos_nxt = 32'd0;
      mb_nxt = 1'b0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (in_acc) begin
      count_nxt = count_nxt + {1'b0, n_wr};
    end
    if (out_acc) begin
      count_nxt = count_nxt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= 32'd0;
      lead_offset_r <= 32'd0;
      pend_r[0] <= 8'h00;
      pend_r[1] <= 8'h00;
      pend_r[2] <= 8'h00;
      pend_cnt_r <= 2'd0;
      need_cnt_r <= 2'd0;
      cp_r <= 21'd0;
      after_cr_r <= 1'b0;
      err_r <= ST_OK;
      err_pos_r <= 32'd0;
      mb_r <= 1'b0;
      head_r <= 3'd0;
      tail_r <= 3'd0;
      count_r <= 4'd0;
    end else begin
      if (in_acc) begin
        byte_offset_r <= byte_offset_nxt;
        lead_offset_r <= lead_offset_nxt;
        pend_r <= pend_nxt;
        pend_cnt_r <= pend_cnt_nxt;
        need_cnt_r <= need_cnt_nxt;
        cp_r <= cp_nxt;
        after_cr_r <= after_cr_nxt;
        err_r <= err_nxt;
        err_pos_r <= err_pos_nxt;
        mb_r <= mb_nxt;
        tail_r <= tail_r + n_wr;
      end
      if (out_acc) begin
        head_r <= head_r + 3'd1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < n_wr) begin
          fifo_r[tail_r + 3'(k)] <= ent[k];
        end
      end
    end
  end

  assign out_out_byte = fifo_r[head_r].data;
  assign out_byte_valid = fifo_r[head_r].valid;
  assign out_doc_done = fifo_r[head_r].done;
  assign out_status = fifo_r[head_r].status;
  assign out_error_offset = fifo_r[head_r].offset;
  assign out_had_multibyte = fifo_r[head_r].multibyte;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 4'(Depth))
    else $error("Result queue occupancy exceeds its depth.");

  a_eod_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_doc |=> out_valid)
    else $error("End of document produced no result.");

  a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_doc_done)
    else $error("Status-only beat without end of document.");

  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_status == ST_OK)
    else $error("Byte beat carries an error status.");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the UTF-8 source normalizer with a built-in byte predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8n_pkg::*;

  localparam int RandomBeats = 380;
  localparam int StallLimit = 2000;
  localparam int SettleCycles = 16;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    result_t    known;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_doc = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_out_byte;
  logic        out_byte_valid;
  logic        out_doc_done;
  logic [2:0]  out_status;
  logic [31:0] out_error_offset;
  logic        out_had_multibyte;

  bit          beat_typed = 1'b0;
  result_t     beat_known = '0;
  bit          steady = 1'b0;

  logic [31:0] next_offset;
  logic [31:0] char_start;
  logic [7:0]  held [3];
  logic [1:0]  held_count;
  logic [1:0]  bytes_left;
  logic [20:0] cp_acc;
  logic        saw_cr;
  status_t     err_code;
  logic [31:0] err_at;
  logic        saw_multibyte;

  result_t     fresh[$];
  result_t     normalized_due[$];
  stim_row_t   opening_rows[$];
  logic [7:0]  doc_bytes[$];

  int failures = 0;
  int sent_beats = 0;
  int stall_cycles = 0;
  int docs_done = 0;
  int docs_failed = 0;
  int byte_beats = 0;
  int status_beats = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  utf8_source_normalizer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_doc    (in_end_of_doc),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_out_byte     (out_out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_doc_done     (out_doc_done),
    .out_status       (out_status),
    .out_error_offset (out_error_offset),
    .out_had_multibyte(out_had_multibyte)
  );

  function automatic void clear_decoder();
    next_offset = '0;
    char_start = '0;
    held[0] = '0;
    held[1] = '0;
    held[2] = '0;
    held_count = '0;
    bytes_left = '0;
    cp_acc = '0;
    saw_cr = 1'b0;
    err_code = ST_OK;
    err_at = '0;
    saw_multibyte = 1'b0;
  endfunction

  function automatic void record_error(input status_t code, input logic [31:0] pos);
    err_code = code;
    err_at = pos;
    bytes_left = '0;
    held_count = '0;
  endfunction

  function automatic result_t make_result(input logic [7:0] d, input logic v);
    result_t r;
    r.data = v ? d : 8'h00;
    r.valid = v;
    r.done = 1'b0;
    r.status = err_code;
    r.offset = (err_code != ST_OK) ? err_at : 32'd0;
    r.multibyte = saw_multibyte;
    return r;
  endfunction

  function automatic void normalize_byte(input logic [7:0] b, input logic last);
    logic [31:0] here;
    logic [7:0]  emit [4];
    int          n;
    int          width;
    logic [20:0] lowest;
    logic [20:0] cp;
    here = next_offset;
    n = 0;
    next_offset = next_offset + 32'd1;
    fresh.delete();
    if (err_code == ST_OK) begin
      if (bytes_left != 0) begin
        if (b[7:6] != 2'b10) begin
          record_error(ST_INVALID, char_start);
        end else begin
          cp_acc = {cp_acc[14:0], b[5:0]};
          bytes_left = bytes_left - 2'd1;
          if (bytes_left != 0) begin
            if (held_count < 2'd3) begin
              held[held_count] = b;
              held_count = held_count + 2'd1;
            end
          end else begin
            width = int'(held_count) + 1;
            lowest = (width == 2) ? 21'h80 : ((width == 3) ? 21'h800 : 21'h10000);
            cp = cp_acc;
            if (cp < lowest) begin
              record_error(ST_OVERLONG, char_start);
            end else if (cp >= 21'h00D800 && cp <= 21'h00DFFF) begin
              record_error(ST_SURROGATE, char_start);
            end else if (cp > 21'h10FFFF) begin
              record_error(ST_RANGE, char_start);
            end else begin
              if (!(width == 3 && char_start == 32'd0 && cp == 21'h00FEFF)) begin
                for (int i = 0; i < int'(held_count); i++) begin
                  emit[n] = held[i];
                  n++;
                end
                emit[n] = b;
                n++;
                saw_multibyte = 1'b1;
              end
              held_count = '0;
            end
          end
        end
      end else if (b < 8'h80) begin
        if (b == CharCr) begin
          emit[n] = CharLf;
          n++;
          saw_cr = 1'b1;
        end else if (b == CharLf && saw_cr) begin
          saw_cr = 1'b0;
        end else begin
          emit[n] = b;
          n++;
          saw_cr = 1'b0;
        end
      end else begin
        saw_cr = 1'b0;
        if (b < 8'hC0 || b >= 8'hF8) begin
          record_error(ST_INVALID, here);
        end else begin
          char_start = here;
          held[0] = b;
          held_count = 2'd1;
          if (b < 8'hE0) begin
            cp_acc = {16'd0, b[4:0]};
            bytes_left = 2'd1;
          end else if (b < 8'hF0) begin
            cp_acc = {17'd0, b[3:0]};
            bytes_left = 2'd2;
          end else begin
            cp_acc = {18'd0, b[2:0]};
            bytes_left = 2'd3;
          end
        end
      end
      if (last && err_code == ST_OK && bytes_left != 0) begin
        record_error(ST_TRUNC, char_start);
      end
    end
    for (int k = 0; k < n; k++) begin
      fresh.insert(fresh.size(), make_result(emit[k], 1'b1));
    end
    if (last) begin
      if (n == 0) begin
        fresh.insert(fresh.size(), make_result(8'h00, 1'b0));
      end
      fresh[fresh.size() - 1].done = 1'b1;
      clear_decoder();
    end
  endfunction

  function automatic stim_row_t plain(input logic [7:0] d, input logic last);
    stim_row_t r;
    r.data = d;
    r.last = last;
    r.typed = 1'b0;
    r.known = '0;
    return r;
  endfunction

  function automatic stim_row_t exact(input logic [7:0] d, input logic last,
                                      input logic [7:0] od, input logic ov,
                                      input logic odone, input status_t st,
                                      input logic [31:0] off, input logic mb);
    stim_row_t r;
    r.data = d;
    r.last = last;
    r.typed = 1'b1;
    r.known.data = od;
    r.known.valid = ov;
    r.known.done = odone;
    r.known.status = st;
    r.known.offset = off;
    r.known.multibyte = mb;
    return r;
  endfunction

  function automatic void add_row(input stim_row_t r);
    opening_rows.insert(opening_rows.size(), r);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    doc_bytes.insert(doc_bytes.size(), b);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic void push_codepoint(input logic [20:0] cp, input int width);
    case (width)
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // A width of zero picks one at random, weighted toward plain ASCII.
  function automatic void push_valid(input int width);
    int          w;
    int          r;
    logic [20:0] lo;
    logic [20:0] hi;
    logic [20:0] cp;
    w = width;
    if (w == 0) begin
      r = $urandom_range(0, 9);
      w = (r < 4) ? 1 : ((r < 6) ? 2 : ((r < 8) ? 3 : 4));
    end
    if (w == 1) begin
      r = $urandom_range(0, 11);
      if (r < 2) add_byte(CharCr);
      else if (r < 4) add_byte(CharLf);
      else if (r == 4) add_byte($urandom_range(0, 1) ? 8'h7F : 8'h00);
      else add_byte(8'($urandom_range(0, 127)));
    end else begin
      lo = (w == 2) ? 21'h80 : ((w == 3) ? 21'h800 : 21'h10000);
      hi = (w == 2) ? 21'h7FF : ((w == 3) ? 21'hFFFF : 21'h10FFFF);
      r = $urandom_range(0, 7);
      cp = (r == 0) ? lo : ((r == 1) ? hi : 21'($urandom_range(lo, hi)));
      if (cp >= 21'h00D800 && cp <= 21'h00DFFF) cp = cp - 21'h800;
      push_codepoint(cp, w);
    end
  endfunction

  function automatic void push_broken();
    int          w;
    logic [20:0] lowest;
    case ($urandom_range(0, 6))
      0: add_byte(8'($urandom_range(8'h80, 8'hBF)));
      1: add_byte(8'($urandom_range(8'hF8, 8'hFF)));
      2: begin
        w = $urandom_range(2, 4);
        lowest = (w == 2) ? 21'h80 : ((w == 3) ? 21'h800 : 21'h10000);
        push_codepoint($urandom_range(0, 1) ? lowest - 21'd1
                                            : 21'($urandom_range(0, lowest - 1)), w);
      end
      3: push_codepoint(21'($urandom_range(21'h00D800, 21'h00DFFF)), 3);
      4: push_codepoint(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
      5: begin
        w = $urandom_range(2, 4);
        push_valid(w);
        repeat ($urandom_range(1, w - 1)) void'(doc_bytes.pop_back());
        add_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7F))
                                      : 8'($urandom_range(8'hC0, 8'hFF)));
      end
      default: add_byte(8'($urandom_range(0, 255)));
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  task automatic send_beat(input stim_row_t r);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= r.data;
    in_end_of_doc <= r.last;
    beat_typed <= r.typed;
    beat_known <= r.known;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (normalized_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_document();
    int nchars;
    int bad_at;
    int w;
    doc_bytes.delete();
    if ($urandom_range(0, 3) == 0) begin
      add_byte(8'hEF);
      add_byte(8'hBB);
      add_byte(8'hBF);
    end
    nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    bad_at = ($urandom_range(0, 9) < 3) ? $urandom_range(0, nchars - 1) : -1;
    for (int i = 0; i < nchars; i++) begin
      if (i == bad_at) push_broken();
      else push_valid(0);
    end
    if ($urandom_range(0, 9) == 0) begin
      w = $urandom_range(2, 4);
      push_valid(w);
      repeat ($urandom_range(1, w - 1)) void'(doc_bytes.pop_back());
    end
    foreach (doc_bytes[i]) begin
      send_beat(plain(doc_bytes[i], i == doc_bytes.size() - 1));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sent_beats++;
        normalize_byte(in_data_byte, in_end_of_doc);
        if (beat_typed) begin
          normalized_due.insert(normalized_due.size(), beat_known);
        end else begin
          foreach (fresh[i]) normalized_due.insert(normalized_due.size(), fresh[i]);
        end
      end
      if (out_valid && out_ready) begin
        if (normalized_due.size() == 0) begin
          $error("unexpected result beat: byte 0x%0h status %0d", out_out_byte, out_status);
          failures++;
        end else begin
          result_t want;
          want = normalized_due.pop_front();
          check_field("out_byte", want.data, out_out_byte);
          check_field("byte_valid", want.valid, out_byte_valid);
          check_field("doc_done", want.done, out_doc_done);
          check_field("status", want.status, out_status);
          check_field("error_offset", want.offset, out_error_offset);
          check_field("had_multibyte", want.multibyte, out_had_multibyte);
        end
        if (out_byte_valid) byte_beats++;
        else status_beats++;
        if (out_doc_done) begin
          docs_done++;
          if (out_status != ST_OK) docs_failed++;
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
  end

  initial begin
    forever begin
      if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk);
    $display("[utf8_source_normalizer] ERROR");
    $finish;
  end

  initial begin
    clear_decoder();
    add_row(plain(8'hEF, 1'b0));
    add_row(plain(8'hBB, 1'b0));
    add_row(plain(8'hBF, 1'b0));
    add_row(exact(8'h00, 1'b0, 8'h00, 1'b1, 1'b0, ST_OK, 32'd0, 1'b0));
    add_row(exact(CharCr, 1'b0, CharLf, 1'b1, 1'b0, ST_OK, 32'd0, 1'b0));
    add_row(plain(CharLf, 1'b0));
    add_row(plain(8'hC3, 1'b0));
    add_row(plain(8'hA9, 1'b0));
    add_row(plain(8'hF0, 1'b0));
    add_row(plain(8'h9F, 1'b0));
    add_row(plain(8'h98, 1'b0));
    add_row(plain(8'h80, 1'b0));
    add_row(exact(8'h80, 1'b1, 8'h00, 1'b0, 1'b1, ST_INVALID, 32'd12, 1'b1));
    add_row(plain(8'hC0, 1'b0));
    add_row(exact(8'h80, 1'b1, 8'h00, 1'b0, 1'b1, ST_OVERLONG, 32'd0, 1'b0));
    add_row(exact(8'hFF, 1'b1, 8'h00, 1'b0, 1'b1, ST_INVALID, 32'd0, 1'b0));
    add_row(plain(8'hED, 1'b0));
    add_row(plain(8'hA0, 1'b0));
    add_row(exact(8'h80, 1'b1, 8'h00, 1'b0, 1'b1, ST_SURROGATE, 32'd0, 1'b0));
    add_row(plain(8'hF4, 1'b0));
    add_row(plain(8'h90, 1'b0));
    add_row(plain(8'h80, 1'b0));
    add_row(exact(8'h80, 1'b1, 8'h00, 1'b0, 1'b1, ST_RANGE, 32'd0, 1'b0));
    add_row(plain(8'hE2, 1'b0));
    add_row(plain(8'h41, 1'b0));
    add_row(exact(8'h7F, 1'b1, 8'h00, 1'b0, 1'b1, ST_INVALID, 32'd0, 1'b0));
    add_row(exact(8'hC3, 1'b1, 8'h00, 1'b0, 1'b1, ST_TRUNC, 32'd0, 1'b0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i]) send_beat(opening_rows[i]);
    drain();

    while (sent_beats < RandomBeats + opening_rows.size()) begin
      steady = ($urandom_range(0, 4) == 0);
      send_document();
      if ($urandom_range(0, 7) == 0) drain();
    end
    steady = 1'b0;
    drain();
    repeat (SettleCycles) @(posedge clk);

    $display("Run covered %0d documents (%0d ending in an error) from %0d input beats.",
             docs_done, docs_failed, sent_beats);
    $display("Receiver took %0d byte beats and %0d status-only beats.",
             byte_beats, status_beats);
    if (failures == 0) begin
      $display("[utf8_source_normalizer] OK");
    end else begin
      $display("[utf8_source_normalizer] ERROR");
    end
    $finish;
  end

endmodule
